// ===== sv/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types, constants and helpers shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int UNIT_W = 21;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [UNIT_W-1:0] REPLACEMENT = 21'h00FFFD;
	localparam logic [UNIT_W-1:0] MAX_SCALAR  = 21'h10FFFF;
	localparam logic [UNIT_W-1:0] SURR_LO     = 21'h00D800;
	localparam logic [UNIT_W-1:0] SURR_HI     = 21'h00DFFF;
	localparam logic [UNIT_W-1:0] BMP_MAX     = 21'h00FFFF;
	localparam logic [UNIT_W-1:0] SUPP_BASE   = 21'h010000;
	localparam logic [UNIT_W-1:0] HIGH_BASE   = 21'h00D800;
	localparam logic [UNIT_W-1:0] LOW_BASE    = 21'h00DC00;
	localparam logic [UNIT_W-1:0] HIGH_LAST   = 21'h00DBFF;

	// register indexes
	localparam logic [0:0] REG_UTF16_OUTPUT = 1'b0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [UNIT_W-1:0] unit_value;
		logic              last_of_run;
	} out_item_t;

	// open sequence state
	typedef struct packed {
		logic [UNIT_W-1:0] partial_code;
		logic [1:0]        bytes_expected;
		logic [1:0]        bytes_received;
	} dec_state_t;

	// up to two result units for one byte
	typedef struct packed {
		logic [1:0] count;
		out_item_t  unit0;
		out_item_t  unit1;
	} dec_res_t;

	// smallest legal value for a sequence with the given continuation count
	function automatic logic [UNIT_W-1:0] seq_floor(input logic [1:0] need);
		logic [UNIT_W-1:0] f;
		case (need)
			2'd1: f = 21'h000080;
			2'd2: f = 21'h000800;
			2'd3: f = 21'h010000;
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

// ===== sv/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// utf8d_decode
// Combinational decode of one byte against the open sequence state.
// ----------------------------------------------------------------------------
module utf8d_decode (
	input  utf8d_pkg::in_item_t   item,
	input  utf8d_pkg::dec_state_t st,
	input  logic                  utf16_mode,
	output utf8d_pkg::dec_res_t   res,
	output utf8d_pkg::dec_state_t nxt
);

	logic [1:0]                   need;
	logic [7:0]                   b;
	logic                         fin;
	logic                         beg_emit;
	logic [utf8d_pkg::UNIT_W-1:0] beg_unit;
	utf8d_pkg::dec_state_t        beg_state;
	utf8d_pkg::dec_state_t        closed;
	logic [utf8d_pkg::UNIT_W-1:0] new_part;
	logic [1:0]                   new_rcv;
	logic [utf8d_pkg::UNIT_W-1:0] cp_raw;
	logic [utf8d_pkg::UNIT_W-1:0] cp;
	logic [utf8d_pkg::UNIT_W-1:0] v;
	logic [utf8d_pkg::UNIT_W-1:0] hi_unit;
	logic [utf8d_pkg::UNIT_W-1:0] lo_unit;
	logic                         split;

	assign b      = item.data_byte;
	assign fin    = item.end_of_text;
	assign closed = '0;

	// lead byte classification
	always_comb begin
		if (b >= 8'hC2 && b <= 8'hDF) begin
			need = 2'd1;
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			need = 2'd2;
		end else if (b >= 8'hF0 && b <= 8'hF4) begin
			need = 2'd3;
		end else begin
			need = 2'd0;
		end
	end

	// decode as a fresh byte with no sequence open
	always_comb begin
		beg_state = closed;
		beg_emit  = 1'b1;
		beg_unit  = utf8d_pkg::REPLACEMENT;
		if (b[7] == 1'b0) begin
			beg_unit = {13'd0, b};
		end else if (need != 2'd0 && !fin) begin
			beg_emit                 = 1'b0;
			beg_state.bytes_expected = need;
			case (need)
				2'd1: beg_state.partial_code = {16'd0, b[4:0]};
				2'd2: beg_state.partial_code = {17'd0, b[3:0]};
				default: beg_state.partial_code = {18'd0, b[2:0]};
			endcase
		end
	end

	// continuation path and scalar check
	assign new_part = {st.partial_code[14:0], b[5:0]};
	assign new_rcv  = st.bytes_received + 2'd1;
	assign cp_raw   = (new_part < utf8d_pkg::seq_floor(st.bytes_expected))
		? utf8d_pkg::REPLACEMENT : new_part;
	assign cp = (cp_raw > utf8d_pkg::MAX_SCALAR ||
		(cp_raw >= utf8d_pkg::SURR_LO && cp_raw <= utf8d_pkg::SURR_HI))
		? utf8d_pkg::REPLACEMENT : cp_raw;
	assign v       = cp - utf8d_pkg::SUPP_BASE;
	assign hi_unit = utf8d_pkg::HIGH_BASE + {11'd0, v[19:10]};
	assign lo_unit = utf8d_pkg::LOW_BASE + {11'd0, v[9:0]};
	assign split   = utf16_mode && (cp > utf8d_pkg::BMP_MAX);

	// select results and next state
	always_comb begin
		res = '0;
		nxt = st;
		if (st.bytes_expected == 2'd0) begin
			res.count            = {1'b0, beg_emit};
			res.unit0.unit_value = beg_unit;
			nxt                  = beg_state;
		end else if (b[7:6] == 2'b10) begin
			if (new_rcv >= st.bytes_expected) begin
				nxt = closed;
				if (split) begin
					res.count            = 2'd2;
					res.unit0.unit_value = hi_unit;
					res.unit1.unit_value = lo_unit;
				end else begin
					res.count            = 2'd1;
					res.unit0.unit_value = cp;
				end
			end else if (fin) begin
				nxt                  = closed;
				res.count            = 2'd1;
				res.unit0.unit_value = utf8d_pkg::REPLACEMENT;
			end else begin
				nxt.partial_code   = new_part;
				nxt.bytes_received = new_rcv;
			end
		end else begin
			// broken sequence: replacement, then the byte afresh
			res.unit0.unit_value = utf8d_pkg::REPLACEMENT;
			res.unit1.unit_value = beg_unit;
			res.count            = beg_emit ? 2'd2 : 2'd1;
			nxt                  = beg_state;
		end
		res.unit0.last_of_run = (res.count == 2'd1);
		res.unit1.last_of_run = (res.count == 2'd2);
	end

endmodule

// ===== sv/utf8d_outq.sv =====
// ----------------------------------------------------------------------------
// utf8d_outq
// Two-slot result register that hands out the units of one byte in order.
// ----------------------------------------------------------------------------
module utf8d_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  utf8d_pkg::dec_res_t  res,
	input  logic                 unit_stall,
	output logic                 load_ok,
	output logic                 unit_valid,
	output utf8d_pkg::out_item_t unit_item
);

	logic [1:0]           cnt_q;
	utf8d_pkg::out_item_t slot0_q;
	utf8d_pkg::out_item_t slot1_q;
	logic                 pop;

	assign unit_valid = (cnt_q != 2'd0);
	assign unit_item  = slot0_q;
	assign pop        = unit_valid && !unit_stall;
	// a new byte's units go in only once the buffer drains this cycle
	assign load_ok    = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= res.unit0;
			slot1_q <= res.unit1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

// ===== sv/utf8_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Path: an accepted byte waits in the input register, then its units are loaded into
// the two-slot result register, which shows the first. Throughput: one byte per cycle
// while the output does not stall; a byte giving two units holds the input while it drains.
// Reset: no sequence open, result register empty, utf16_output set to 1.
// Decodes a UTF-8 byte stream into code points or UTF-16 code units.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            byte_valid,
	output logic                            byte_stall,
	input  utf8d_pkg::in_item_t             byte_item,
	output logic                            unit_valid,
	input  logic                            unit_stall,
	output utf8d_pkg::out_item_t            unit_item,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [utf8d_pkg::ADDR_W-1:0]    paddr,
	input  logic [utf8d_pkg::DATA_W-1:0]    pwdata,
	output logic [utf8d_pkg::DATA_W-1:0]    prdata,
	output logic                            pready
);

	utf8d_pkg::in_item_t   item_s1;
	logic                  vld_s1;
	utf8d_pkg::dec_state_t st_q;
	utf8d_pkg::dec_state_t st_nxt;
	utf8d_pkg::dec_res_t   res;
	logic                  mode_q;
	logic                  load_ok;
	logic                  load;
	logic                  take;

	assign pready     = 1'b1;
	assign load       = vld_s1 && load_ok;
	assign byte_stall = vld_s1 && !load_ok;
	assign take       = byte_valid && !byte_stall;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (psel && penable && pwrite &&
			paddr[utf8d_pkg::ADDR_W-1] == utf8d_pkg::REG_UTF16_OUTPUT) begin
			mode_q <= pwdata[0];
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		if (paddr[utf8d_pkg::ADDR_W-1] == utf8d_pkg::REG_UTF16_OUTPUT) begin
			prdata[0] = mode_q;
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (load) begin
			vld_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= byte_item;
		end
	end

	// sequence state advances as each byte is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (load) begin
			st_q <= st_nxt;
		end
	end

	utf8d_decode u_decode (
		.item       (item_s1),
		.st         (st_q),
		.utf16_mode (mode_q),
		.res        (res),
		.nxt        (st_nxt)
	);

	utf8d_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.res        (res),
		.unit_stall (unit_stall),
		.load_ok    (load_ok),
		.unit_valid (unit_valid),
		.unit_item  (unit_item)
	);

endmodule

// ===== sv/utf8d_checker.sv =====
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 byte_valid,
	input logic                 byte_stall,
	input logic                 unit_valid,
	input logic                 unit_stall,
	input utf8d_pkg::out_item_t unit_item
);

	// a stalled unit holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && unit_stall |=> unit_valid && $stable(unit_item))
		else $error("stalled unit changed");

	// input stalls only while results are waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |-> unit_valid)
		else $error("input stalled with empty result register");

	// the second unit of a byte follows right after the first
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && !unit_stall && !unit_item.last_of_run |=> unit_valid)
		else $error("second unit of a byte missing");

	// a unit that is not last is a replacement or a high surrogate
	a_first_kind: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && !unit_item.last_of_run |->
		(unit_item.unit_value == utf8d_pkg::REPLACEMENT) ||
		(unit_item.unit_value >= utf8d_pkg::HIGH_BASE &&
		 unit_item.unit_value <= utf8d_pkg::HIGH_LAST))
		else $error("unexpected leading unit");

	// values stay in scalar range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid |-> unit_item.unit_value <= utf8d_pkg::MAX_SCALAR)
		else $error("unit above scalar range");

endmodule

bind utf8_stream_decoder_top utf8d_checker u_utf8d_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.unit_valid (unit_valid),
	.unit_stall (unit_stall),
	.unit_item  (unit_item)
);

// ===== tb/sv/tb_utf8_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_top
// Self-checking bench for the UTF-8 stream decoder. Bytes go in over the
// valid/stall channel with random gaps. An in-bench decoder predicts every
// code point or UTF-16 unit, and each unit that comes out is compared with
// the oldest prediction. Covers the mode register over APB, malformed input,
// text ends and long output back-pressure.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int UNIT_W        = utf8d_pkg::UNIT_W;
	localparam int ADDR_W        = utf8d_pkg::ADDR_W;
	localparam int DATA_W        = utf8d_pkg::DATA_W;
	localparam int HOLD_CYCLES   = 300;
	localparam int SPARE_REG_IDX = 1;	// first index past the register map
	localparam int ITEM_TARGET   = 730;
	localparam int DIRECTED_N    = 27;

	// directed bytes; only the last one closes the text
	localparam logic [7:0] DIRECTED [DIRECTED_N] = '{
		8'h00, 8'h7F,
		8'hC2, 8'h80,
		8'hEF, 8'hBF, 8'hBF,
		8'hF0, 8'h90, 8'h80, 8'h80,
		8'hFF, 8'h80,
		8'hE0, 8'h9F, 8'hBF,
		8'hED, 8'hA0, 8'h80,
		8'hF4, 8'h90, 8'h80, 8'h80,
		8'hC2, 8'h41,
		8'hE2, 8'h82
	};

	logic                   clk;
	logic                   arst_n;
	logic                   byte_valid;
	logic                   byte_stall;
	utf8d_pkg::in_item_t    byte_item;
	logic                   unit_valid;
	logic                   unit_stall;
	utf8d_pkg::out_item_t   unit_item;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_W-1:0]      paddr;
	logic [DATA_W-1:0]      pwdata;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;

	// predicted decoder state and mode
	logic                   utf16_mode = 1'b1;
	logic [UNIT_W-1:0]      acc_code = '0;
	logic [1:0]             need_cnt = '0;
	logic [1:0]             got_cnt = '0;
	utf8d_pkg::out_item_t   step_units [2];
	int                     step_n;
	utf8d_pkg::out_item_t   unit_expect [$];

	logic [7:0]             piece_q [$];

	bit                     tx_idle_on = 1'b1;
	bit                     rx_idle_on = 1'b1;
	int                     hold_req = 0;
	int                     hold_done = 0;

	int                     items_sent = 0;
	int                     texts_ended = 0;
	int                     units_checked = 0;
	int                     reg_ops = 0;
	int                     mismatches = 0;

	utf8_stream_decoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit_item  (unit_item),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic void flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s expected %h got %h", what, want, got);
	endfunction

	// mostly short runs, a few long ones
	function automatic int pick_run();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// ---------------------------------------------------------------- predictor

	function automatic void push_unit(input logic [UNIT_W-1:0] v);
		step_units[step_n].unit_value = v;
		step_units[step_n].last_of_run = 1'b0;
		step_n++;
	endfunction

	// scalar check, then surrogate split in utf16 mode
	function automatic void emit_code(input logic [UNIT_W-1:0] cp);
		logic [UNIT_W-1:0] v;
		logic [UNIT_W-1:0] off;
		v = cp;
		if (v > utf8d_pkg::MAX_SCALAR ||
			(v >= utf8d_pkg::SURR_LO && v <= utf8d_pkg::SURR_HI))
			v = utf8d_pkg::REPLACEMENT;
		if (utf16_mode && v > utf8d_pkg::BMP_MAX) begin
			off = v - utf8d_pkg::SUPP_BASE;
			push_unit(utf8d_pkg::HIGH_BASE + (off >> 10));
			push_unit(utf8d_pkg::LOW_BASE + (off & 21'h0003FF));
		end else begin
			push_unit(v);
		end
	endfunction

	function automatic void close_open();
		acc_code = '0;
		need_cnt = '0;
		got_cnt = '0;
	endfunction

	// byte seen with no sequence open
	function automatic void open_lead(input logic [7:0] b, input logic fin);
		logic [1:0] need;
		if (b < 8'h80) begin
			emit_code({13'b0, b});
			return;
		end
		if (b >= 8'hC2 && b <= 8'hDF)
			need = 2'd1;
		else if (b >= 8'hE0 && b <= 8'hEF)
			need = 2'd2;
		else if (b >= 8'hF0 && b <= 8'hF4)
			need = 2'd3;
		else
			need = 2'd0;
		if (need == 2'd0 || fin) begin
			emit_code(utf8d_pkg::REPLACEMENT);
			return;
		end
		case (need)
			2'd1: acc_code = {16'b0, b[4:0]};
			2'd2: acc_code = {17'b0, b[3:0]};
			default: acc_code = {18'b0, b[2:0]};
		endcase
		need_cnt = need;
		got_cnt = 2'd0;
	endfunction

	// work out the units one accepted byte gives and queue them
	function automatic void predict_byte(input utf8d_pkg::in_item_t it);
		logic [7:0]        b;
		logic              fin;
		logic [UNIT_W-1:0] cp;
		logic [UNIT_W-1:0] lowest;
		b = it.data_byte;
		fin = it.end_of_text;
		step_n = 0;
		if (need_cnt == 2'd0) begin
			open_lead(b, fin);
		end else if (b[7:6] == 2'b10) begin
			acc_code = {acc_code[14:0], b[5:0]};
			got_cnt = got_cnt + 2'd1;
			if (got_cnt >= need_cnt) begin
				case (need_cnt)
					2'd1: lowest = 21'h000080;
					2'd2: lowest = 21'h000800;
					default: lowest = 21'h010000;
				endcase
				cp = (acc_code < lowest) ? utf8d_pkg::REPLACEMENT : acc_code;
				close_open();
				emit_code(cp);
			end else if (fin) begin
				close_open();
				emit_code(utf8d_pkg::REPLACEMENT);
			end
		end else begin
			// broken sequence, then the byte starts over
			close_open();
			emit_code(utf8d_pkg::REPLACEMENT);
			open_lead(b, fin);
		end
		if (step_n > 0)
			step_units[step_n-1].last_of_run = 1'b1;
		for (int i = 0; i < step_n; i++)
			unit_expect = {unit_expect, step_units[i]};
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic void add_byte(input logic [7:0] b);
		piece_q = {piece_q, b};
	endfunction

	function automatic void encode(input logic [UNIT_W-1:0] cp, input int len);
		case (len)
			1: add_byte({1'b0, cp[6:0]});
			2: begin
				add_byte({3'b110, cp[10:6]});
				add_byte({2'b10, cp[5:0]});
			end
			3: begin
				add_byte({4'b1110, cp[15:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
			default: begin
				add_byte({5'b11110, cp[20:18]});
				add_byte({2'b10, cp[17:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function automatic logic [UNIT_W-1:0] legal_cp(input int len);
		case (len)
			2: return UNIT_W'($urandom_range(32'h80, 32'h7FF));
			3: return UNIT_W'($urandom_range(32'h800, 32'hFFFF));
			default: return UNIT_W'($urandom_range(32'h10000, 32'h10FFFF));
		endcase
	endfunction

	// one character, mostly well formed, sometimes broken or noise
	function automatic void gen_piece();
		int r;
		int len;
		int keep;
		piece_q.delete();
		r = $urandom_range(0, 99);
		if (r < 28) begin
			encode(UNIT_W'($urandom_range(0, 127)), 1);
		end else if (r < 70) begin
			len = (r < 42) ? 2 : (r < 56) ? 3 : 4;
			encode(legal_cp(len), len);
		end else if (r < 75) begin
			// overlong
			len = $urandom_range(2, 4);
			case (len)
				2: encode(UNIT_W'($urandom_range(0, 32'h7F)), 2);
				3: encode(UNIT_W'($urandom_range(0, 32'h7FF)), 3);
				default: encode(UNIT_W'($urandom_range(0, 32'hFFFF)), 4);
			endcase
		end else if (r < 78) begin
			encode(UNIT_W'($urandom_range(32'hD800, 32'hDFFF)), 3);
		end else if (r < 81) begin
			encode(UNIT_W'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
		end else if (r < 90) begin
			// cut short, the next piece breaks it
			len = $urandom_range(2, 4);
			encode(legal_cp(len), len);
			keep = $urandom_range(1, len - 1);
			while (piece_q.size() > keep)
				void'(piece_q.pop_back());
		end else begin
			add_byte(8'($urandom_range(0, 255)));
		end
	endfunction

	// offer one item and wait until it is taken; called at a rising edge
	task automatic send_byte(input logic [7:0] b, input logic eot);
		utf8d_pkg::in_item_t it;
		bit                  taken;
		it.data_byte = b;
		it.end_of_text = eot;
		byte_item <= it;
		byte_valid <= 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !byte_stall;
			if (taken)
				predict_byte(it);
			@(posedge clk);
		end
		items_sent++;
		if (eot)
			texts_ended++;
	endtask

	// random gap on the sending side
	task automatic pace();
		int g;
		if (tx_idle_on && $urandom_range(0, 99) < 35) begin
			g = pick_run();
			byte_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_random_text(input int count);
		int  stop_at;
		bit  ends;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			gen_piece();
			ends = ($urandom_range(0, 9) == 0);
			foreach (piece_q[i]) begin
				send_byte(piece_q[i], ends && (i == piece_q.size() - 1));
				pace();
			end
		end
	endtask

	// sender stops until every predicted unit has come out
	task automatic wait_drained();
		byte_valid <= 1'b0;
		while (unit_expect.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- apb

	task automatic reg_write(input int idx, input logic [DATA_W-1:0] val);
		bit rdy;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == int'(utf8d_pkg::REG_UTF16_OUTPUT))
			utf16_mode = val[0];
		reg_ops++;
		@(posedge clk);
	endtask

	// read the mode register and compare with the predicted value
	task automatic reg_check();
		bit                rdy;
		logic [DATA_W-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'(int'(utf8d_pkg::REG_UTF16_OUTPUT) * 4);
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			got = prdata;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		reg_ops++;
		if (got !== {{(DATA_W-1){1'b0}}, utf16_mode})
			flag_mismatch("utf16_output readback", {{(DATA_W-1){1'b0}}, utf16_mode}, got);
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------- receiver

	initial begin : unit_receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		unit_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_done != hold_req)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				if (hold_left == 0)
					hold_done++;
				unit_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				unit_stall <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
				stall_left = pick_run() - 1;
				unit_stall <= 1'b1;
			end else begin
				unit_stall <= 1'b0;
			end
		end
	end

	// compare each accepted unit with the oldest prediction
	always @(negedge clk) begin : unit_checker
		utf8d_pkg::out_item_t want;
		if (arst_n && unit_valid && !unit_stall) begin
			if (unit_expect.size() == 0) begin
				flag_mismatch("unit with nothing expected", '0, 32'(unit_item.unit_value));
			end else begin
				want = unit_expect.pop_front();
				if (want.unit_value !== unit_item.unit_value)
					flag_mismatch("unit_value", 32'(want.unit_value),
						32'(unit_item.unit_value));
				if (want.last_of_run !== unit_item.last_of_run)
					flag_mismatch("last_of_run", 32'(want.last_of_run),
						32'(unit_item.last_of_run));
				units_checked++;
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// extremes, every lead class and each malformed case, utf16 mode
	task automatic test_directed();
		reg_check();
		for (int i = 0; i < DIRECTED_N; i++) begin
			send_byte(DIRECTED[i], i == DIRECTED_N - 1);
			pace();
		end
		wait_drained();
	endtask

	// mode register: spare index ignored, both settings exercised
	task automatic test_mode_switch();
		reg_write(SPARE_REG_IDX, {31'h5A5A5A5A, 1'b0});
		reg_check();
		reg_write(int'(utf8d_pkg::REG_UTF16_OUTPUT), {31'h7FFFFFFF, 1'b0});
		reg_check();
		send_random_text(110);
		wait_drained();
		reg_write(int'(utf8d_pkg::REG_UTF16_OUTPUT), 32'h0000_0001);
		reg_check();
		send_random_text(110);
		wait_drained();
		reg_write(int'(utf8d_pkg::REG_UTF16_OUTPUT), 32'(($urandom() << 1)));
		reg_check();
		send_random_text(110);
		wait_drained();
	endtask

	// receiver holds off for a long stretch while bytes keep coming
	task automatic test_backpressure();
		reg_write(int'(utf8d_pkg::REG_UTF16_OUTPUT), 32'h0000_0001);
		tx_idle_on = 1'b0;
		hold_req++;
		send_random_text(80);
		byte_valid <= 1'b0;
		while (hold_done != hold_req)
			@(posedge clk);
		tx_idle_on = 1'b1;
		wait_drained();
	endtask

	// sender stops and lets everything drain between bursts
	task automatic test_sender_pause();
		for (int i = 0; i < 3; i++) begin
			send_random_text(30);
			wait_drained();
		end
	endtask

	// remaining random traffic with stretches of no idling on either side
	task automatic test_random();
		int phase;
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			tx_idle_on = (phase % 3) != 1;
			rx_idle_on = (phase % 3) != 2;
			if (phase == 2) begin
				wait_drained();
				reg_write(int'(utf8d_pkg::REG_UTF16_OUTPUT), 32'h0000_0000);
			end
			send_random_text(50);
			phase++;
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_mode_switch();
		test_backpressure();
		test_sender_pause();
		test_random();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("sent %0d bytes in %0d finished texts, checked %0d output units",
			items_sent, texts_ended, units_checked);
		$display("%0d register accesses, both output modes, one %0d-cycle output hold",
			reg_ops, HOLD_CYCLES);
		if (mismatches == 0 && unit_expect.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d units still expected", mismatches,
				unit_expect.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule
